>>> rtl/bounded_stack_with_peek_assert.svh
// Assertion macros for the bounded stack RTL.
// Included by modules that check their own logic; no other dependencies.
`ifndef BOUNDED_STACK_WITH_PEEK_ASSERT_SVH
`define BOUNDED_STACK_WITH_PEEK_ASSERT_SVH
`ifndef ASSERT_OFF
// check prop on every clock edge while reset is low
`define BSP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check prop on every clock edge, reset included
`define BSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BSP_ASSERT(lbl, clk, rst, prop, msg)
`define BSP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> rtl/bsp_pkg.sv
// Shared types and constants for the bounded stack with peek.
// No dependencies; imported by every RTL module of the block.
`default_nettype none

package bsp_pkg;

   localparam int DEF_MAX_DEPTH = 256;
   localparam int DATA_W        = 32;
   localparam int POS_W         = 9;
   localparam int OCC_W         = 9;

   // command codes
   localparam logic [1:0] CMD_PUSH = 2'd0;
   localparam logic [1:0] CMD_POP  = 2'd1;
   localparam logic [1:0] CMD_PEEK = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_OVERFLOW = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;
   localparam logic [1:0] ST_BAD_POS  = 2'd3;

   localparam logic [OCC_W-1:0]         LIMIT_RESET = 9'd256;
   localparam logic signed [DATA_W-1:0] NO_VALUE    = -32'sd1;

   typedef enum logic {
      SEQ_IDLE,
      SEQ_PEEK
   } seq_type;

   typedef struct packed {
      logic [1:0]               command;
      logic signed [DATA_W-1:0] push_value;
      logic [POS_W-1:0]         peek_position;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] read_value;
      logic [1:0]               status;
      logic [OCC_W-1:0]         occupancy;
      logic                     is_empty;
      logic                     is_full;
   } rsp_type;

   // per-cycle controls broadcast to every cell
   typedef struct packed {
      logic push;
      logic pop;
      logic load;
      logic shift;
   } cell_ctl_type;

endpackage

`default_nettype wire

>>> rtl/bsp_cell.sv
// One stack cell: a stored word plus a read-chain word for peeks.
// Depends on bsp_pkg for the control struct and widths.
`default_nettype none

module bsp_cell import bsp_pkg::*; (
   input  logic                     clock,
   input  cell_ctl_type             ctl,
   input  logic signed [DATA_W-1:0] up_data,
   input  logic signed [DATA_W-1:0] dn_data,
   input  logic signed [DATA_W-1:0] dn_rd,
   output logic signed [DATA_W-1:0] data,
   output logic signed [DATA_W-1:0] rd
);

   logic signed [DATA_W-1:0] data_ff, data_in;
   logic signed [DATA_W-1:0] rd_ff, rd_in;

   // push moves words away from the top, pop moves them toward it
   always_comb begin
      data_in = data_ff;
      if (ctl.push) begin
         data_in = up_data;
      end else if (ctl.pop) begin
         data_in = dn_data;
      end
   end

   // read chain: load from the next cell down the stack, then walk toward the top
   always_comb begin
      rd_in = rd_ff;
      if (ctl.load) begin
         rd_in = dn_data;
      end else if (ctl.shift) begin
         rd_in = dn_rd;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      rd_ff   <= rd_in;
   end

   assign data = data_ff;
   assign rd   = rd_ff;

endmodule

`default_nettype wire

>>> rtl/bsp_ctrl.sv
// Command sequencer: limit register, entry count, peek walk and result register.
// Depends on bsp_pkg and the assertion macros header.
`default_nettype none
`include "bounded_stack_with_peek_assert.svh"

module bsp_ctrl import bsp_pkg::*; #(
   parameter int MAX_DEPTH = DEF_MAX_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  req_type                  req_item,
   input  logic                     csr_we,
   input  logic [OCC_W-1:0]         csr_wdata,
   input  logic signed [DATA_W-1:0] top_data,
   input  logic signed [DATA_W-1:0] peek_data,
   output cell_ctl_type             cell_ctl,
   output logic                     rsp_valid,
   output rsp_type                  rsp_item
);

   localparam int CW = $clog2(MAX_DEPTH + 1);
   localparam int W  = (CW > POS_W) ? CW : POS_W;

   seq_type                  state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [POS_W-1:0]         remain_ff, remain_in;
   logic [OCC_W-1:0]         limit_ff, limit_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;
   logic                     accept;
   logic [W-1:0]             count_w, pos_w, lim_w;
   logic signed [DATA_W-1:0] rd_val;
   logic [1:0]               st;

   // limit register, written whenever the enable is high
   assign limit_in = csr_we ? csr_wdata : limit_ff;

   // effective limit: zero acts as one, clamp to the cell count
   always_comb begin
      lim_w = (limit_ff == '0) ? W'(1) : W'(limit_ff);
      if (lim_w > W'(MAX_DEPTH)) begin
         lim_w = W'(MAX_DEPTH);
      end
   end

   assign accept  = start && (state_ff == SEQ_IDLE);
   assign busy    = (state_ff != SEQ_IDLE);
   assign count_w = W'(count_ff);
   assign pos_w   = W'(req_item.peek_position);

   // next state, cell controls and result contents
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      remain_in    = remain_ff;
      cell_ctl     = '0;
      rsp_valid_in = 1'b0;
      rd_val       = NO_VALUE;
      st           = ST_OK;
      case (state_ff)
         SEQ_IDLE: begin
            if (start) begin
               rsp_valid_in = 1'b1;
               case (req_item.command)
                  CMD_PUSH: begin
                     if (count_w >= lim_w) begin
                        st = ST_OVERFLOW;
                     end else begin
                        cell_ctl.push = 1'b1;
                        count_in      = count_ff + 1'b1;
                     end
                  end
                  CMD_POP: begin
                     if (count_ff == '0) begin
                        st = ST_EMPTY;
                     end else begin
                        cell_ctl.pop = 1'b1;
                        count_in     = count_ff - 1'b1;
                        rd_val       = top_data;
                     end
                  end
                  CMD_PEEK: begin
                     if (req_item.peek_position == '0 || pos_w > count_w) begin
                        st = ST_BAD_POS;
                     end else if (req_item.peek_position == POS_W'(1)) begin
                        rd_val = top_data;
                     end else begin
                        // walk the read chain; result comes from the sequencer
                        rsp_valid_in  = 1'b0;
                        cell_ctl.load = 1'b1;
                        remain_in     = req_item.peek_position - 1'b1;
                        state_in      = SEQ_PEEK;
                     end
                  end
                  default: begin
                     // unused code: no operation
                  end
               endcase
            end
         end
         SEQ_PEEK: begin
            if (remain_ff == POS_W'(1)) begin
               rsp_valid_in = 1'b1;
               rd_val       = peek_data;
               state_in     = SEQ_IDLE;
            end else begin
               cell_ctl.shift = 1'b1;
               remain_in      = remain_ff - 1'b1;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   // result fields reflect the count after this command
   always_comb begin
      rsp_in.read_value = rd_val;
      rsp_in.status     = st;
      rsp_in.occupancy  = OCC_W'(count_in);
      rsp_in.is_empty   = (count_in == '0);
      rsp_in.is_full    = (W'(count_in) >= lim_w);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         count_ff     <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      remain_ff <= remain_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // checks
   `BSP_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> (!rsp_valid_ff && state_ff == SEQ_IDLE && count_ff == '0), "reset did not clear control state")
   `BSP_ASSERT(a_rsp_has_cause, clock, reset, rsp_valid_ff |-> $past(accept || state_ff == SEQ_PEEK), "result without an accepted item")
   `BSP_ASSERT(a_peek_keeps_count, clock, reset, (!$past(reset) && state_ff == SEQ_PEEK) |-> (count_ff == $past(count_ff)), "count changed during peek walk")
   `BSP_ASSERT(a_count_step, clock, reset, (!$past(reset) && count_ff != $past(count_ff)) |-> (count_ff == $past(count_ff) + 1'b1 || count_ff == $past(count_ff) - 1'b1), "count moved by more than one")
   `BSP_ASSERT(a_overflow_holds, clock, reset, (accept && req_item.command == CMD_PUSH && count_w >= lim_w) |=> (count_ff == $past(count_ff)), "push on full stack changed count")

endmodule

`default_nettype wire

>>> rtl/bounded_stack_with_peek.sv
// Top level of the bounded LIFO stack with peek: a row of cells and a sequencer.
// Depends on bsp_pkg, bsp_cell and bsp_ctrl.
//
//   channel   ports                      direction   moves
//   request   start, busy, req_item      in          one command item
//   result    rsp_valid, rsp_item        out         one result item, one-cycle strobe
//   config    csr_we, csr_wdata          in          stack limit write
//
// For push, pop, an invalid peek and a peek of the top word the block stays idle;
// the result shows the cycle after the item is accepted.
// A peek at position p (2 or more) loads the cell read chain, then walks it toward
// the top; busy is high meanwhile and the result is taken from the top cell's chain.
// Synchronous reset empties the stack and sets the limit to 256; no clearing pass.
// Results cannot be held off: each is valid for exactly one cycle.
`default_nettype none

module bounded_stack_with_peek import bsp_pkg::*; #(
   parameter int MAX_DEPTH = DEF_MAX_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_item,
   output logic             rsp_valid,
   output rsp_type          rsp_item,
   input  logic             csr_we,
   input  logic [OCC_W-1:0] csr_wdata
);

   cell_ctl_type             cell_ctl;
   logic signed [DATA_W-1:0] cell_data [MAX_DEPTH];
   logic signed [DATA_W-1:0] cell_rd   [MAX_DEPTH];

   // sequencer
   bsp_ctrl #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .top_data  (cell_data[0]),
      .peek_data (cell_rd[0]),
      .cell_ctl  (cell_ctl),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // cell row, index 0 is the top of the stack
   for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
      logic signed [DATA_W-1:0] up_data;
      logic signed [DATA_W-1:0] dn_data;
      logic signed [DATA_W-1:0] dn_rd;

      if (i == 0) begin : g_top
         assign up_data = req_item.push_value;
      end else begin : g_mid
         assign up_data = cell_data[i-1];
      end

      if (i == MAX_DEPTH - 1) begin : g_last
         assign dn_data = cell_data[i];
         assign dn_rd   = cell_rd[i];
      end else begin : g_inner
         assign dn_data = cell_data[i+1];
         assign dn_rd   = cell_rd[i+1];
      end

      bsp_cell u_cell (
         .clock   (clock),
         .ctl     (cell_ctl),
         .up_data (up_data),
         .dn_data (dn_data),
         .dn_rd   (dn_rd),
         .data    (cell_data[i]),
         .rd      (cell_rd[i])
      );
   end

endmodule

`default_nettype wire

>>> tb/bounded_stack_with_peek_test.sv
// Self-checking testbench for the bounded LIFO stack with peek: directed corner cases, then
// random command phases under several stack limits, each result checked against a predictor.
// Depends on bsp_pkg and the bounded_stack_with_peek RTL.
`timescale 1ns / 1ps

module bounded_stack_with_peek_test;
   import bsp_pkg::*;

   localparam int         STACK_DEPTH    = DEF_MAX_DEPTH;
   localparam int         WATCHDOG_LIMIT = 4000;
   localparam int         TAIL_CYCLES    = 300;
   localparam logic [1:0] CMD_NOP        = 2'd3;

   // Predicts each result and holds the results still owed by the block
   class stack_scoreboard;
      logic signed [DATA_W-1:0] entry_words[STACK_DEPTH];
      int                       entry_total;
      logic [OCC_W-1:0]         limit_reg;
      rsp_type                  pending_results[$];
      int                       mismatches;

      function new();
         entry_total = 0;
         limit_reg   = LIMIT_RESET;
         mismatches  = 0;
      endfunction

      task report_mismatch(string what);
         if (mismatches < 40)
            $display("[%0t] mismatch: %s", $time, what);
         mismatches++;
      endtask

      function void set_limit(logic [OCC_W-1:0] value);
         limit_reg = value;
      endfunction

      function int depth();
         return entry_total;
      endfunction

      function int outstanding();
         return pending_results.size();
      endfunction

      // Applies one command to the stack copy and returns the result it gives
      function rsp_type predict_outcome(req_type item);
         rsp_type outcome;
         int      cap;
         cap = (limit_reg == 0) ? 1 : (limit_reg > STACK_DEPTH) ? STACK_DEPTH : int'(limit_reg);
         outcome.read_value = NO_VALUE;
         outcome.status     = ST_OK;
         case (item.command)
            CMD_PUSH: begin
               if (entry_total >= cap) begin
                  outcome.status = ST_OVERFLOW;
               end else begin
                  entry_words[entry_total] = item.push_value;
                  entry_total++;
               end
            end
            CMD_POP: begin
               if (entry_total == 0) begin
                  outcome.status = ST_EMPTY;
               end else begin
                  entry_total--;
                  outcome.read_value = entry_words[entry_total];
               end
            end
            CMD_PEEK: begin
               if (item.peek_position == 0 || int'(item.peek_position) > entry_total)
                  outcome.status = ST_BAD_POS;
               else
                  outcome.read_value = entry_words[entry_total - int'(item.peek_position)];
            end
            default: ;
         endcase
         outcome.occupancy = entry_total[OCC_W-1:0];
         outcome.is_empty  = (entry_total == 0);
         outcome.is_full   = (entry_total >= cap);
         return outcome;
      endfunction

      function void note_request(req_type item);
         pending_results.push_back(predict_outcome(item));
      endfunction

      task check_result(rsp_type got);
         rsp_type want;
         if (pending_results.size() == 0) begin
            report_mismatch("result with no item pending");
         end else begin
            want = pending_results.pop_front();
            if (got.read_value !== want.read_value)
               report_mismatch($sformatf("read_value %h, predicted %h",
                                         got.read_value, want.read_value));
            if (got.status !== want.status)
               report_mismatch($sformatf("status %0d, predicted %0d", got.status, want.status));
            if (got.occupancy !== want.occupancy)
               report_mismatch($sformatf("occupancy %0d, predicted %0d",
                                         got.occupancy, want.occupancy));
            if (got.is_empty !== want.is_empty)
               report_mismatch($sformatf("is_empty %b, predicted %b",
                                         got.is_empty, want.is_empty));
            if (got.is_full !== want.is_full)
               report_mismatch($sformatf("is_full %b, predicted %b", got.is_full, want.is_full));
         end
      endtask

      task check_drained();
         if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
      endtask
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   req_type          req_item = '0;
   logic             rsp_valid;
   rsp_type          rsp_item;
   logic             csr_we = 1'b0;
   logic [OCC_W-1:0] csr_wdata = '0;

   stack_scoreboard  sb;
   int               quiet_cycles;

   bounded_stack_with_peek dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // Observe both handshakes; watchdog on cycles where no item moves
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid)
            sb.check_result(rsp_item);
         if (start && !busy)
            sb.note_request(req_item);
         if (rsp_valid || (start && !busy)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Present one item and hold it until the block takes it
   task send_item(logic [1:0] command, logic signed [DATA_W-1:0] value,
                  logic [POS_W-1:0] position);
      req_type item;
      item.command       = command;
      item.push_value    = value;
      item.peek_position = position;
      @(negedge clock);
      start    <= 1'b1;
      req_item <= item;
      @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   task idle_gap(int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (cycles - 1)
            @(negedge clock);
      end
   endtask

   task hold_until_drained();
      @(negedge clock);
      start <= 1'b0;
      while (sb.outstanding() != 0)
         @(posedge clock);
   endtask

   // Limit writes only happen with the block idle
   task write_limit(logic [OCC_W-1:0] value);
      hold_until_drained();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      sb.set_limit(value);
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   function logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 15))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return '0;
         3:       return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   // Mostly valid positions, plus zero, one past the top and anything at all
   function logic [POS_W-1:0] pick_position(int occupied);
      int roll;
      roll = $urandom_range(0, 9);
      if (roll <= 6 && occupied > 0)
         return POS_W'($urandom_range(1, occupied));
      else if (roll == 7)
         return POS_W'(occupied + 1);
      else if (roll == 8)
         return '0;
      else
         return POS_W'($urandom_range(0, 511));
   endfunction

   // One random phase: sets the limit, then sends bursts of commands
   task run_phase(logic [OCC_W-1:0] limit_value, int item_count, int push_pct);
      int         burst_left;
      int         roll;
      logic [1:0] command;
      write_limit(limit_value);
      burst_left = 0;
      for (int n = 0; n < item_count; n++) begin
         if (burst_left == 0) begin
            idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
            burst_left = $urandom_range(1, 24);
         end
         burst_left--;
         if ($urandom_range(0, 99) == 0)
            hold_until_drained();
         roll = $urandom_range(0, 99);
         if (roll < 5)
            command = CMD_NOP;
         else if (roll < 5 + push_pct)
            command = CMD_PUSH;
         else if (roll[0])
            command = CMD_POP;
         else
            command = CMD_PEEK;
         send_item(command, pick_value(), pick_position(sb.depth()));
      end
   endtask

   initial begin
      sb = new();
      repeat (3)
         @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty stack, unused code, extreme words, peek edges
      send_item(CMD_POP,  '0, '0);
      send_item(CMD_PEEK, '0, 9'd1);
      send_item(CMD_PEEK, '0, 9'd0);
      send_item(CMD_NOP,  32'sh1234_5678, 9'd3);
      send_item(CMD_PUSH, 32'sh8000_0000, '0);
      send_item(CMD_PUSH, 32'sh7fff_ffff, '1);
      send_item(CMD_PUSH, -32'sd1, '0);
      send_item(CMD_PUSH, '0, '0);
      send_item(CMD_PEEK, '0, 9'd0);
      send_item(CMD_PEEK, '0, 9'd1);
      send_item(CMD_PEEK, '0, 9'd4);
      send_item(CMD_PEEK, '0, 9'd5);
      send_item(CMD_PEEK, '0, 9'd511);
      send_item(CMD_POP,  '0, '0);

      // Limit lowered below occupancy, then limit zero acting as one
      write_limit(9'd2);
      send_item(CMD_PUSH, 32'sh0000_00aa, '0);
      send_item(CMD_PEEK, '0, 9'd3);
      send_item(CMD_POP,  '0, '0);
      send_item(CMD_POP,  '0, '0);
      send_item(CMD_PUSH, 32'sh5555_5555, '0);
      send_item(CMD_PUSH, 32'shaaaa_aaaa, '0);
      write_limit(9'd0);
      send_item(CMD_POP,  '0, '0);
      send_item(CMD_POP,  '0, '0);
      send_item(CMD_PUSH, 32'sh0f0f_0f0f, '0);
      send_item(CMD_PUSH, 32'shf0f0_f0f0, '0);
      send_item(CMD_POP,  '0, '0);

      run_phase(9'd256, 300, 50);
      run_phase(9'd8,   200, 45);
      run_phase(9'd0,   150, 50);
      run_phase(9'd1,   150, 50);
      run_phase(9'd511, 500, 75);
      run_phase(9'd40,  300, 30);
      run_phase(OCC_W'($urandom_range(2, 255)), 200, 50);
      run_phase(9'd300, 150, 50);

      hold_until_drained();
      repeat (TAIL_CYCLES)
         @(posedge clock);
      sb.check_drained();
      if (sb.mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
